// ----- hdl/ctb_pkg.sv -----
// ----------------------------------------------------------------------------
// Clipped transparent blitter package
// Widths, word layouts, command codes and the geometry microprogram shared by
// the blitter modules.
// ----------------------------------------------------------------------------
package ctb_pkg;

   // Pixel stores
   localparam int STORE_DEPTH = 16384;
   localparam int MEM_AW      = $clog2(STORE_DEPTH);
   // Walk addresses must hold row * stride + column for 8-bit geometry.
   localparam int WALK_W      = 17;
   localparam int ADDR_W      = (MEM_AW >= WALK_W) ? MEM_AW + 1 : WALK_W;
   localparam logic [ADDR_W-1:0] DEPTH_LIMIT = ADDR_W'(STORE_DEPTH);

   // Field widths
   localparam int PIX_W     = 8;
   localparam int PADDR_W   = 14;
   localparam int COORD_W   = 10;
   localparam int REG_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int MODE_W    = 2;

   // Request word layout
   localparam int IN_ADDR_LSB    = 0;
   localparam int IN_VALUE_LSB   = IN_ADDR_LSB + PADDR_W;
   localparam int IN_RL_LSB      = IN_VALUE_LSB + PIX_W;
   localparam int IN_RT_LSB      = IN_RL_LSB + COORD_W;
   localparam int IN_RR_LSB      = IN_RT_LSB + COORD_W;
   localparam int IN_RB_LSB      = IN_RR_LSB + COORD_W;
   localparam int IN_DX_LSB      = IN_RB_LSB + COORD_W;
   localparam int IN_DY_LSB      = IN_DX_LSB + COORD_W;
   localparam int IN_DATA_W      = ((IN_DY_LSB + COORD_W + 7) / 8) * 8;
   localparam int USER_MODE_LSB  = 0;
   localparam int USER_TRANS_BIT = USER_MODE_LSB + MODE_W;
   localparam int IN_USER_W      = USER_TRANS_BIT + 1;

   // Response word layout
   localparam int OUT_RD_LSB     = 0;
   localparam int OUT_COPIED_BIT = OUT_RD_LSB + PIX_W;
   localparam int OUT_DATA_W     = ((OUT_COPIED_BIT + 1 + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_WR_SRC,
      MODE_WR_DST,
      MODE_RD_DST,
      MODE_BLIT
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT,
      CSR_DST_WIDTH,
      CSR_DST_HEIGHT,
      CSR_CLIP_LEFT,
      CSR_CLIP_TOP,
      CSR_CLIP_RIGHT,
      CSR_CLIP_BOTTOM
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEOM,
      ST_COPY,
      ST_DRAIN,
      ST_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_FETCH,
      SQ_EXEC
   } seq_state_type;

   // Geometry unit
   localparam int ALU_W = 18;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MAX,
      ALU_MIN,
      ALU_MUL
   } alu_op_type;

   // Operands: outside values first, then the scratch registers.
   typedef enum logic [4:0] {
      OPND_ZERO,
      OPND_REQ_L,
      OPND_REQ_T,
      OPND_REQ_R,
      OPND_REQ_B,
      OPND_DEST_X,
      OPND_DEST_Y,
      OPND_SRC_W,
      OPND_SRC_H,
      OPND_DST_W,
      OPND_CLIP_L,
      OPND_CLIP_T,
      OPND_CLIP_R,
      OPND_CLIP_B,
      OPND_SL,
      OPND_ST,
      OPND_SR,
      OPND_SB,
      OPND_DX,
      OPND_DY,
      OPND_DL,
      OPND_DT,
      OPND_DR,
      OPND_DB,
      OPND_CL,
      OPND_CT,
      OPND_CR,
      OPND_CB,
      OPND_W,
      OPND_H,
      OPND_SA,
      OPND_DA
   } opnd_type;

   localparam int TMP_COUNT = 18;
   localparam int TMP_W     = $clog2(TMP_COUNT);

   typedef struct packed {
      alu_op_type op;
      opnd_type   a;
      opnd_type   b;
      opnd_type   dst;
      logic       chk;   // stop with an empty result when dst <= 0
   } uop_type;

   localparam int UCODE_LEN = 26;
   localparam int PC_W      = $clog2(UCODE_LEN);
   localparam logic [PC_W-1:0] PC_LAST = PC_W'(UCODE_LEN - 1);

   function automatic uop_type ucode(logic [PC_W-1:0] pc);
      uop_type u;
      u = '{ALU_ADD, OPND_ZERO, OPND_ZERO, OPND_SL, 1'b0};
      case (pc)
         // Request against the whole source bitmap
         5'd0:  u = '{ALU_MAX, OPND_REQ_L, OPND_ZERO,   OPND_SL, 1'b0};
         5'd1:  u = '{ALU_MAX, OPND_REQ_T, OPND_ZERO,   OPND_ST, 1'b0};
         5'd2:  u = '{ALU_MIN, OPND_REQ_R, OPND_SRC_W,  OPND_SR, 1'b0};
         5'd3:  u = '{ALU_MIN, OPND_REQ_B, OPND_SRC_H,  OPND_SB, 1'b0};
         5'd4:  u = '{ALU_SUB, OPND_SR,    OPND_SL,     OPND_W,  1'b1};
         5'd5:  u = '{ALU_SUB, OPND_SB,    OPND_ST,     OPND_H,  1'b1};
         // Move to the destination point
         5'd6:  u = '{ALU_SUB, OPND_DEST_X, OPND_REQ_L, OPND_DX, 1'b0};
         5'd7:  u = '{ALU_SUB, OPND_DEST_Y, OPND_REQ_T, OPND_DY, 1'b0};
         5'd8:  u = '{ALU_ADD, OPND_SL,    OPND_DX,     OPND_DL, 1'b0};
         5'd9:  u = '{ALU_ADD, OPND_ST,    OPND_DY,     OPND_DT, 1'b0};
         5'd10: u = '{ALU_ADD, OPND_SR,    OPND_DX,     OPND_DR, 1'b0};
         5'd11: u = '{ALU_ADD, OPND_SB,    OPND_DY,     OPND_DB, 1'b0};
         // Destination clip
         5'd12: u = '{ALU_MAX, OPND_DL,    OPND_CLIP_L, OPND_CL, 1'b0};
         5'd13: u = '{ALU_MAX, OPND_DT,    OPND_CLIP_T, OPND_CT, 1'b0};
         5'd14: u = '{ALU_MIN, OPND_DR,    OPND_CLIP_R, OPND_CR, 1'b0};
         5'd15: u = '{ALU_MIN, OPND_DB,    OPND_CLIP_B, OPND_CB, 1'b0};
         5'd16: u = '{ALU_SUB, OPND_CR,    OPND_CL,     OPND_W,  1'b1};
         5'd17: u = '{ALU_SUB, OPND_CB,    OPND_CT,     OPND_H,  1'b1};
         // Trim the source by the clip amounts
         5'd18: u = '{ALU_SUB, OPND_CL,    OPND_DL,     OPND_DX, 1'b0};
         5'd19: u = '{ALU_SUB, OPND_CT,    OPND_DT,     OPND_DY, 1'b0};
         5'd20: u = '{ALU_ADD, OPND_SL,    OPND_DX,     OPND_SL, 1'b0};
         5'd21: u = '{ALU_ADD, OPND_ST,    OPND_DY,     OPND_ST, 1'b0};
         // Start addresses
         5'd22: u = '{ALU_MUL, OPND_ST,    OPND_SRC_W,  OPND_SA, 1'b0};
         5'd23: u = '{ALU_ADD, OPND_SA,    OPND_SL,     OPND_SA, 1'b0};
         5'd24: u = '{ALU_MUL, OPND_CT,    OPND_DST_W,  OPND_DA, 1'b0};
         5'd25: u = '{ALU_ADD, OPND_DA,    OPND_CL,     OPND_DA, 1'b0};
         default: u = '{ALU_ADD, OPND_ZERO, OPND_ZERO, OPND_SL, 1'b0};
      endcase
      return u;
   endfunction

   typedef struct packed {
      logic signed [COORD_W-1:0] req_l;
      logic signed [COORD_W-1:0] req_t;
      logic signed [COORD_W-1:0] req_r;
      logic signed [COORD_W-1:0] req_b;
      logic signed [COORD_W-1:0] dest_x;
      logic signed [COORD_W-1:0] dest_y;
      logic [REG_W-1:0]          src_w;
      logic [REG_W-1:0]          src_h;
      logic [REG_W-1:0]          dst_w;
      logic [REG_W-1:0]          clip_l;
      logic [REG_W-1:0]          clip_t;
      logic [REG_W-1:0]          clip_r;
      logic [REG_W-1:0]          clip_b;
   } geom_in_type;

   typedef struct packed {
      logic              done;
      logic              ok;
      logic [ADDR_W-1:0] sa;
      logic [ADDR_W-1:0] da;
      logic [REG_W-1:0]  w;
      logic [REG_W-1:0]  h;
   } geom_out_type;

endpackage

// ----- hdl/ctb_geom.sv -----
// ----------------------------------------------------------------------------
// Blit geometry unit
// Runs the clipping microprogram on one shared add, subtract, min, max and
// multiply unit, a fetch state and an execute state per step, and hands back
// the start addresses and the size of the area to copy.
// ----------------------------------------------------------------------------
module ctb_geom (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ctb_pkg::geom_in_type   geom_in,
   output ctb_pkg::geom_out_type  geom_out
);

   ctb_pkg::seq_state_type state_ff, state_in;
   logic [ctb_pkg::PC_W-1:0] pc_ff, pc_in;
   logic signed [ctb_pkg::ALU_W-1:0] a_ff, b_ff;
   logic signed [ctb_pkg::ALU_W-1:0] rf [ctb_pkg::TMP_COUNT];
   logic signed [ctb_pkg::ALU_W-1:0] a_ext, b_ext, res;
   logic [2*ctb_pkg::REG_W-1:0] prod;
   logic [ctb_pkg::TMP_W-1:0] a_idx, b_idx, w_idx;
   logic a_tmp, b_tmp, nonpos, fetch_en, exec_en, finish;
   ctb_pkg::uop_type uop;

   logic done_ff, ok_ff;
   logic [ctb_pkg::ADDR_W-1:0] sa_ff, da_ff;
   logic [ctb_pkg::REG_W-1:0] w_ff, h_ff;

   function automatic logic signed [ctb_pkg::ALU_W-1:0] ext_value(
      ctb_pkg::opnd_type code, ctb_pkg::geom_in_type g);
      logic signed [ctb_pkg::ALU_W-1:0] v;
      v = '0;
      case (code)
         ctb_pkg::OPND_REQ_L:  v = ctb_pkg::ALU_W'(g.req_l);
         ctb_pkg::OPND_REQ_T:  v = ctb_pkg::ALU_W'(g.req_t);
         ctb_pkg::OPND_REQ_R:  v = ctb_pkg::ALU_W'(g.req_r);
         ctb_pkg::OPND_REQ_B:  v = ctb_pkg::ALU_W'(g.req_b);
         ctb_pkg::OPND_DEST_X: v = ctb_pkg::ALU_W'(g.dest_x);
         ctb_pkg::OPND_DEST_Y: v = ctb_pkg::ALU_W'(g.dest_y);
         ctb_pkg::OPND_SRC_W:  v = ctb_pkg::ALU_W'(g.src_w);
         ctb_pkg::OPND_SRC_H:  v = ctb_pkg::ALU_W'(g.src_h);
         ctb_pkg::OPND_DST_W:  v = ctb_pkg::ALU_W'(g.dst_w);
         ctb_pkg::OPND_CLIP_L: v = ctb_pkg::ALU_W'(g.clip_l);
         ctb_pkg::OPND_CLIP_T: v = ctb_pkg::ALU_W'(g.clip_t);
         ctb_pkg::OPND_CLIP_R: v = ctb_pkg::ALU_W'(g.clip_r);
         ctb_pkg::OPND_CLIP_B: v = ctb_pkg::ALU_W'(g.clip_b);
         default:              v = '0;
      endcase
      return v;
   endfunction

   assign uop   = ctb_pkg::ucode(pc_ff);
   assign a_tmp = (uop.a >= ctb_pkg::OPND_SL);
   assign b_tmp = (uop.b >= ctb_pkg::OPND_SL);
   assign a_idx = ctb_pkg::TMP_W'(uop.a - ctb_pkg::OPND_SL);
   assign b_idx = ctb_pkg::TMP_W'(uop.b - ctb_pkg::OPND_SL);
   assign w_idx = ctb_pkg::TMP_W'(uop.dst - ctb_pkg::OPND_SL);
   assign a_ext = ext_value(uop.a, geom_in);
   assign b_ext = ext_value(uop.b, geom_in);

   // Shared unit. Row indexes fed to the multiply are known to fit 8 bits.
   assign prod = a_ff[ctb_pkg::REG_W-1:0] * b_ff[ctb_pkg::REG_W-1:0];

   always_comb begin
      case (uop.op)
         ctb_pkg::ALU_ADD: res = a_ff + b_ff;
         ctb_pkg::ALU_SUB: res = a_ff - b_ff;
         ctb_pkg::ALU_MAX: res = (a_ff > b_ff) ? a_ff : b_ff;
         ctb_pkg::ALU_MIN: res = (a_ff < b_ff) ? a_ff : b_ff;
         ctb_pkg::ALU_MUL: res = ctb_pkg::ALU_W'(prod);
         default:          res = '0;
      endcase
   end

   assign nonpos = res[ctb_pkg::ALU_W-1] || (res == '0);
   assign finish = (uop.chk && nonpos) || (pc_ff == ctb_pkg::PC_LAST);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctb_pkg::SQ_IDLE:  if (start) state_in = ctb_pkg::SQ_FETCH;
         ctb_pkg::SQ_FETCH: state_in = ctb_pkg::SQ_EXEC;
         ctb_pkg::SQ_EXEC: begin
            if (finish) state_in = ctb_pkg::SQ_IDLE;
            else        state_in = ctb_pkg::SQ_FETCH;
         end
         default:           state_in = ctb_pkg::SQ_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      fetch_en = 1'b0;
      exec_en  = 1'b0;
      pc_in    = pc_ff;
      unique case (state_ff)
         ctb_pkg::SQ_IDLE:  if (start) pc_in = '0;
         ctb_pkg::SQ_FETCH: fetch_en = 1'b1;
         ctb_pkg::SQ_EXEC: begin
            exec_en = 1'b1;
            if (!finish) pc_in = pc_ff + 1'b1;
         end
         default:           pc_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctb_pkg::SQ_IDLE;
         pc_ff    <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         done_ff  <= exec_en && finish;
      end
   end

   // Scratch register file: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (exec_en) rf[w_idx] <= res;
      if (fetch_en) begin
         a_ff <= a_tmp ? rf[a_idx] : a_ext;
         b_ff <= b_tmp ? rf[b_idx] : b_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         ok_ff <= !(uop.chk && nonpos);
         if (uop.dst == ctb_pkg::OPND_SA) sa_ff <= ctb_pkg::ADDR_W'(res);
         if (uop.dst == ctb_pkg::OPND_DA) da_ff <= ctb_pkg::ADDR_W'(res);
         if (uop.dst == ctb_pkg::OPND_W)  w_ff  <= res[ctb_pkg::REG_W-1:0];
         if (uop.dst == ctb_pkg::OPND_H)  h_ff  <= res[ctb_pkg::REG_W-1:0];
      end
   end

   assign geom_out.done = done_ff;
   assign geom_out.ok   = ok_ff;
   assign geom_out.sa   = sa_ff;
   assign geom_out.da   = da_ff;
   assign geom_out.w    = w_ff;
   assign geom_out.h    = h_ff;

endmodule

// ----- hdl/clipped_transparent_blitter.sv -----
// ----------------------------------------------------------------------------
// Clipped transparent blitter
// Two 8-bit pixel stores with pixel access and a clipped, color-keyed
// rectangle copy from the source store into the destination store.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the req_ stream, one word each; the command kind and the
// transparent flag ride in req_tuser. Every command returns exactly one word
// on the rsp_ stream with the read pixel and the copy status. Bitmap sizes
// and the destination clip rectangle are written through the csr_ port,
// which is always ready and must only be written while no command is open.
//
// Pixel writes and reads pass from idle to the done state; there the response
// register is loaded, raising rsp_tvalid, and the sequencer returns to idle.
// A blit first runs the clipping microprogram on the shared geometry unit,
// a fetch and an execute state for each of its 26 steps (it stops early when
// a clip leaves nothing), then walks the clipped area at one pixel per cycle
// through the source store read port.
// One command is worked on at a time; req_tready is high only when idle.
//
// The response sits in an output register, so the next command is accepted
// while a response still waits; if the receiver stalls, the finished command
// holds in its last step until the output register frees up.
// Reset clears the control state and the configuration registers to zero.
// The pixel stores are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module clipped_transparent_blitter (
   input  logic                              clock,
   input  logic                              reset,
   // Command word
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_addr, pixel_value, rect_left, rect_top, rect_right, rect_bottom,
   // dest_x, dest_y, zero fill
   input  logic [ctb_pkg::IN_DATA_W-1:0]     req_tdata,
   // mode, transparent
   input  logic [ctb_pkg::IN_USER_W-1:0]     req_tuser,
   // Response word
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_data, copied, zero fill
   output logic [ctb_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ctb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ctb_pkg::REG_W-1:0]         csr_data
);

   // Command fields
   ctb_pkg::mode_type req_mode;
   logic                          req_trans;
   logic [ctb_pkg::PADDR_W-1:0]   req_addr;
   logic [ctb_pkg::PIX_W-1:0]     req_value;
   logic [ctb_pkg::ADDR_W-1:0]    req_addr_ext;
   logic [ctb_pkg::MEM_AW-1:0]    pix_idx;
   logic                          req_addr_ok, accept;

   // Configuration
   logic [ctb_pkg::REG_W-1:0] src_w_ff, src_h_ff, dst_w_ff;
   logic [ctb_pkg::REG_W-1:0] clip_l_ff, clip_t_ff, clip_r_ff, clip_b_ff;

   // Captured command
   ctb_pkg::mode_type mode_ff;
   logic addr_ok_ff, trans_ff, ok_ff;
   logic signed [ctb_pkg::COORD_W-1:0] rl_ff, rt_ff, rr_ff, rb_ff, dx_ff, dy_ff;

   ctb_pkg::top_state_type state_ff, state_in;
   ctb_pkg::geom_in_type   geom_in;
   ctb_pkg::geom_out_type  geom_out;
   logic geom_start;

   // Copy walker
   logic [ctb_pkg::ADDR_W-1:0] sa_ff, sa_in, da_ff, da_in;
   logic [ctb_pkg::ADDR_W-1:0] sa_row_ff, sa_row_in, da_row_ff, da_row_in;
   logic [ctb_pkg::REG_W-1:0]  col_ff, col_in, row_ff, row_in, w_ff, h_ff;
   logic copy_en, last_col, last_row, in_range;
   logic wr_pend_ff, wr_pend_in;
   logic [ctb_pkg::MEM_AW-1:0] wr_addr_ff;

   // Pixel stores
   logic [ctb_pkg::PIX_W-1:0] src_mem [ctb_pkg::STORE_DEPTH];
   logic [ctb_pkg::PIX_W-1:0] dst_mem [ctb_pkg::STORE_DEPTH];
   logic [ctb_pkg::PIX_W-1:0] src_q_ff, dst_q_ff, dst_wdata;
   logic [ctb_pkg::MEM_AW-1:0] dst_waddr;
   logic src_we, src_re, dst_we, dst_re;

   // Response register
   logic rsp_valid_ff, rsp_copied_ff, rsp_load, rsp_free;
   logic [ctb_pkg::PIX_W-1:0] rsp_data_ff;

   assign req_mode  = ctb_pkg::mode_type'(
                      req_tuser[ctb_pkg::USER_MODE_LSB +: ctb_pkg::MODE_W]);
   assign req_trans = req_tuser[ctb_pkg::USER_TRANS_BIT];
   assign req_addr  = req_tdata[ctb_pkg::IN_ADDR_LSB +: ctb_pkg::PADDR_W];
   assign req_value = req_tdata[ctb_pkg::IN_VALUE_LSB +: ctb_pkg::PIX_W];
   assign req_addr_ext = ctb_pkg::ADDR_W'(req_addr);
   assign req_addr_ok  = req_addr_ext < ctb_pkg::DEPTH_LIMIT;
   assign pix_idx      = req_addr_ext[ctb_pkg::MEM_AW-1:0];
   assign accept       = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Configuration registers. The destination height plays no part in a
   // copy, so a write to it is taken and dropped.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= '0;
         src_h_ff  <= '0;
         dst_w_ff  <= '0;
         clip_l_ff <= '0;
         clip_t_ff <= '0;
         clip_r_ff <= '0;
         clip_b_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (ctb_pkg::csr_idx_type'(csr_index))
            ctb_pkg::CSR_SRC_WIDTH:   src_w_ff  <= csr_data;
            ctb_pkg::CSR_SRC_HEIGHT:  src_h_ff  <= csr_data;
            ctb_pkg::CSR_DST_WIDTH:   dst_w_ff  <= csr_data;
            ctb_pkg::CSR_DST_HEIGHT:  ;
            ctb_pkg::CSR_CLIP_LEFT:   clip_l_ff <= csr_data;
            ctb_pkg::CSR_CLIP_TOP:    clip_t_ff <= csr_data;
            ctb_pkg::CSR_CLIP_RIGHT:  clip_r_ff <= csr_data;
            ctb_pkg::CSR_CLIP_BOTTOM: clip_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Command capture
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         addr_ok_ff <= req_addr_ok;
         trans_ff   <= req_trans;
         rl_ff      <= req_tdata[ctb_pkg::IN_RL_LSB +: ctb_pkg::COORD_W];
         rt_ff      <= req_tdata[ctb_pkg::IN_RT_LSB +: ctb_pkg::COORD_W];
         rr_ff      <= req_tdata[ctb_pkg::IN_RR_LSB +: ctb_pkg::COORD_W];
         rb_ff      <= req_tdata[ctb_pkg::IN_RB_LSB +: ctb_pkg::COORD_W];
         dx_ff      <= req_tdata[ctb_pkg::IN_DX_LSB +: ctb_pkg::COORD_W];
         dy_ff      <= req_tdata[ctb_pkg::IN_DY_LSB +: ctb_pkg::COORD_W];
      end
      if (geom_out.done) ok_ff <= geom_out.ok;
   end

   always_comb begin
      geom_in.req_l  = rl_ff;
      geom_in.req_t  = rt_ff;
      geom_in.req_r  = rr_ff;
      geom_in.req_b  = rb_ff;
      geom_in.dest_x = dx_ff;
      geom_in.dest_y = dy_ff;
      geom_in.src_w  = src_w_ff;
      geom_in.src_h  = src_h_ff;
      geom_in.dst_w  = dst_w_ff;
      geom_in.clip_l = clip_l_ff;
      geom_in.clip_t = clip_t_ff;
      geom_in.clip_r = clip_r_ff;
      geom_in.clip_b = clip_b_ff;
   end

   ctb_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .start    (geom_start),
      .geom_in  (geom_in),
      .geom_out (geom_out)
   );

   // ------------------------------------------------------------------
   // Command sequencer
   // ------------------------------------------------------------------
   assign last_col = (col_ff == w_ff - 1'b1);
   assign last_row = (row_ff == h_ff - 1'b1);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctb_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == ctb_pkg::MODE_BLIT) state_in = ctb_pkg::ST_GEOM;
               else                                state_in = ctb_pkg::ST_DONE;
            end
         end
         ctb_pkg::ST_GEOM: begin
            if (geom_out.done) begin
               if (geom_out.ok) state_in = ctb_pkg::ST_COPY;
               else             state_in = ctb_pkg::ST_DONE;
            end
         end
         ctb_pkg::ST_COPY:  if (last_col && last_row) state_in = ctb_pkg::ST_DRAIN;
         ctb_pkg::ST_DRAIN: state_in = ctb_pkg::ST_DONE;
         ctb_pkg::ST_DONE:  if (rsp_free) state_in = ctb_pkg::ST_IDLE;
         default:           state_in = ctb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      copy_en    = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ctb_pkg::ST_IDLE:  req_tready = 1'b1;
         ctb_pkg::ST_GEOM:  ;
         ctb_pkg::ST_COPY:  copy_en = 1'b1;
         ctb_pkg::ST_DRAIN: ;
         ctb_pkg::ST_DONE:  rsp_load = rsp_free;
         default:           ;
      endcase
   end

   assign geom_start = accept && (req_mode == ctb_pkg::MODE_BLIT);
   assign src_we     = accept && (req_mode == ctb_pkg::MODE_WR_SRC) && req_addr_ok;
   assign dst_re     = accept && (req_mode == ctb_pkg::MODE_RD_DST) && req_addr_ok;

   // ------------------------------------------------------------------
   // Copy walker: one source read per cycle, the destination write follows
   // in the next cycle when the read data is back. Pixels whose source or
   // destination address falls past a store are skipped.
   // ------------------------------------------------------------------
   assign in_range   = (sa_ff < ctb_pkg::DEPTH_LIMIT) && (da_ff < ctb_pkg::DEPTH_LIMIT);
   assign src_re     = copy_en && in_range;
   assign wr_pend_in = src_re;

   always_comb begin
      sa_in     = sa_ff;
      da_in     = da_ff;
      sa_row_in = sa_row_ff;
      da_row_in = da_row_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (geom_out.done) begin
         sa_in     = geom_out.sa;
         da_in     = geom_out.da;
         sa_row_in = geom_out.sa;
         da_row_in = geom_out.da;
         col_in    = '0;
         row_in    = '0;
      end else if (copy_en) begin
         if (last_col) begin
            sa_row_in = sa_row_ff + ctb_pkg::ADDR_W'(src_w_ff);
            da_row_in = da_row_ff + ctb_pkg::ADDR_W'(dst_w_ff);
            sa_in     = sa_row_in;
            da_in     = da_row_in;
            col_in    = '0;
            row_in    = row_ff + 1'b1;
         end else begin
            sa_in  = sa_ff + 1'b1;
            da_in  = da_ff + 1'b1;
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sa_ff     <= sa_in;
      da_ff     <= da_in;
      sa_row_ff <= sa_row_in;
      da_row_ff <= da_row_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      if (geom_out.done) begin
         w_ff <= geom_out.w;
         h_ff <= geom_out.h;
      end
      if (src_re) wr_addr_ff <= da_ff[ctb_pkg::MEM_AW-1:0];
   end

   // Destination write port: pixel write commands, or copy writes that the
   // color key lets through.
   always_comb begin
      dst_we    = 1'b0;
      dst_waddr = wr_addr_ff;
      dst_wdata = src_q_ff;
      if (accept && (req_mode == ctb_pkg::MODE_WR_DST) && req_addr_ok) begin
         dst_we    = 1'b1;
         dst_waddr = pix_idx;
         dst_wdata = req_value;
      end else if (wr_pend_ff && !(trans_ff && (src_q_ff == '0))) begin
         dst_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (src_we) src_mem[pix_idx] <= req_value;
      if (src_re) src_q_ff <= src_mem[sa_ff[ctb_pkg::MEM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dst_we) dst_mem[dst_waddr] <= dst_wdata;
      if (dst_re) dst_q_ff <= dst_mem[pix_idx];
   end

   // ------------------------------------------------------------------
   // Control registers and response
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctb_pkg::ST_IDLE;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_pend_ff <= wr_pend_in;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff   <= (mode_ff == ctb_pkg::MODE_RD_DST && addr_ok_ff) ? dst_q_ff : '0;
         rsp_copied_ff <= (mode_ff != ctb_pkg::MODE_BLIT) || ok_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ctb_pkg::OUT_DATA_W'({rsp_copied_ff, rsp_data_ff});

endmodule

// ----- hdl/ctb_checker.sv -----
// ----------------------------------------------------------------------------
// Blitter port checker
// Watches the command and response streams of the blitter over time.
// ----------------------------------------------------------------------------
module ctb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ctb_pkg::OUT_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while the previous one is open");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response word out of reset");

   a_no_data_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[ctb_pkg::OUT_COPIED_BIT]
      |-> rsp_tdata[ctb_pkg::OUT_RD_LSB +: ctb_pkg::PIX_W] == '0)
      else $error("clipped-away blit returned pixel data");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ctb_pkg::OUT_DATA_W-1:ctb_pkg::OUT_COPIED_BIT+1] == '0)
      else $error("response fill bits not zero");

endmodule

bind clipped_transparent_blitter ctb_checker u_checker (.*);
